FILE: rtl/hcbd_pkg.sv
`default_nettype none

package hcbd_pkg;

  // Width of the hex digit counter; it covers SIZE_DIGITS up to 15.
  localparam int CNT_W = 4;

  // Depth of the queue between the classifier and the decode machine.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // One body byte with its character class worked out up front.
  typedef struct packed {
    logic [7:0] data;
    logic       is_cr;
    logic       is_lf;
    logic       is_sep;
    logic       is_hex;
    logic [3:0] hex_val;
  } hcbd_item_t;

endpackage

`default_nettype wire

FILE: rtl/hcbd_front.sv
`default_nettype none

module hcbd_front
  import hcbd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_body_byte,
  output logic            push_valid,
  output hcbd_item_t      push_item,
  input  wire logic       push_ready
);

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SPACE = 8'h20;

  logic       stage_valid_r;
  logic       stage_valid_nxt;
  hcbd_item_t stage_item_r;
  hcbd_item_t class_item;
  logic       load;

  always_comb begin
    class_item         = '0;
    class_item.data    = in_body_byte;
    class_item.is_cr   = (in_body_byte == CH_CR);
    class_item.is_lf   = (in_body_byte == CH_LF);
    class_item.is_sep  = (in_body_byte == CH_SEMI) || (in_body_byte == CH_SPACE);
    case (in_body_byte) inside
      [8'h30:8'h39]: begin
        class_item.is_hex  = 1'b1;
        class_item.hex_val = 4'(in_body_byte - 8'h30);
      end
      [8'h41:8'h46]: begin
        class_item.is_hex  = 1'b1;
        class_item.hex_val = 4'(in_body_byte - 8'h37);
      end
      [8'h61:8'h66]: begin
        class_item.is_hex  = 1'b1;
        class_item.hex_val = 4'(in_body_byte - 8'h57);
      end
      default: begin
        class_item.is_hex  = 1'b0;
        class_item.hex_val = 4'd0;
      end
    endcase
  end

  assign in_ready   = !stage_valid_r || push_ready;
  assign load       = in_valid && in_ready;
  assign push_valid = stage_valid_r;
  assign push_item  = stage_item_r;

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    if (load) begin
      stage_valid_nxt = 1'b1;
    end else if (push_ready) begin
      stage_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage_item_r <= class_item;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/hcbd_queue.sv
`default_nettype none

module hcbd_queue
  import hcbd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push_valid,
  input  hcbd_item_t      push_item,
  output logic            push_ready,
  output logic            pop_valid,
  output hcbd_item_t      pop_item,
  input  wire logic       pop_ready
);

  hcbd_item_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r;
  logic [QCNT_W-1:0]   count_nxt;
  logic                do_push;
  logic                do_pop;

  localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QCNT_W-1:0] FULL_CNT = QCNT_W'(QUEUE_DEPTH);

  assign push_ready = (count_r != FULL_CNT);
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/hcbd_back.sv
`default_nettype none

module hcbd_back
  import hcbd_pkg::*;
#(
  parameter int SIZE_DIGITS = 9
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_valid,
  input  hcbd_item_t      q_item,
  output logic            q_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_payload_byte,
  output logic            out_message_done
);

  localparam int ACC_W = 4 * SIZE_DIGITS;
  localparam logic [CNT_W-1:0] SD_CNT = CNT_W'(SIZE_DIGITS);

  typedef enum logic [2:0] {
    PH_SIZE,
    PH_SIZE_LF,
    PH_DATA,
    PH_TRAIL1,
    PH_TRAIL2,
    PH_FINAL,
    PH_FINAL_LF
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   cnt_inc;
  logic [ACC_W-1:0]   rem_r, rem_nxt;
  logic               closed_r, closed_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_byte_r, out_byte_nxt;
  logic               out_done_r, out_done_nxt;
  logic               take;
  logic               emit;

  assign q_ready = !out_valid_r || out_ready;
  assign take    = q_valid && q_ready;
  assign cnt_inc = cnt_r + 1'b1;

  always_comb begin
    phase_nxt    = phase_r;
    acc_nxt      = acc_r;
    cnt_nxt      = cnt_r;
    rem_nxt      = rem_r;
    closed_nxt   = closed_r;
    emit         = 1'b0;
    out_byte_nxt = 8'd0;
    out_done_nxt = 1'b0;
    case (phase_r)
      PH_SIZE_LF: begin
        if (q_item.is_lf) begin
          acc_nxt    = '0;
          cnt_nxt    = '0;
          closed_nxt = 1'b0;
          if (acc_r == '0) begin
            phase_nxt = PH_FINAL;
          end else begin
            rem_nxt   = acc_r;
            phase_nxt = PH_DATA;
          end
        end else if (!q_item.is_cr) begin
          phase_nxt = PH_SIZE;
        end
      end
      PH_DATA: begin
        emit         = 1'b1;
        out_byte_nxt = q_item.data;
        if (rem_r != '0) begin
          rem_nxt = rem_r - 1'b1;
        end
        // The chunk ends when at most one byte was still due.
        if (rem_r[ACC_W-1:1] == '0) begin
          phase_nxt = PH_TRAIL1;
        end
      end
      PH_TRAIL1: begin
        phase_nxt = PH_TRAIL2;
      end
      PH_TRAIL2: begin
        phase_nxt  = PH_SIZE;
        acc_nxt    = '0;
        cnt_nxt    = '0;
        closed_nxt = 1'b0;
      end
      PH_FINAL: begin
        if (q_item.is_cr) begin
          phase_nxt = PH_FINAL_LF;
        end
      end
      PH_FINAL_LF: begin
        if (q_item.is_lf) begin
          phase_nxt    = PH_SIZE;
          acc_nxt      = '0;
          cnt_nxt      = '0;
          closed_nxt   = 1'b0;
          rem_nxt      = '0;
          emit         = 1'b1;
          out_done_nxt = 1'b1;
        end else if (!q_item.is_cr) begin
          phase_nxt = PH_FINAL;
        end
      end
      default: begin
        phase_nxt = PH_SIZE;
        if (q_item.is_cr) begin
          closed_nxt = 1'b1;
          phase_nxt  = PH_SIZE_LF;
        end else if (closed_r) begin
          closed_nxt = 1'b1;
        end else if (q_item.is_sep) begin
          closed_nxt = 1'b1;
        end else if (!q_item.is_hex) begin
          // A bad size character makes the size zero, which ends the message.
          acc_nxt    = '0;
          closed_nxt = 1'b1;
        end else begin
          acc_nxt = ACC_W'({acc_r, q_item.hex_val});
          cnt_nxt = cnt_inc;
          if (cnt_inc >= SD_CNT) begin
            closed_nxt = 1'b1;
          end
        end
      end
    endcase

    if (take) begin
      out_valid_nxt = emit;
    end else begin
      out_valid_nxt = out_valid_r && !out_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SIZE;
      acc_r       <= '0;
      cnt_r       <= '0;
      rem_r       <= '0;
      closed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        phase_r  <= phase_nxt;
        acc_r    <= acc_nxt;
        cnt_r    <= cnt_nxt;
        rem_r    <= rem_nxt;
        closed_r <= closed_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
    if (take && emit) begin
      out_byte_r <= out_byte_nxt;
      out_done_r <= out_done_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_payload_byte = out_byte_r;
  assign out_message_done = out_done_r;

  a_done_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> out_byte_r == 8'd0)
    else $error("done result carries a nonzero byte");

  a_data_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> rem_r != '0)
    else $error("data phase with no bytes remaining");

  a_digit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= SD_CNT)
    else $error("digit count past the size field limit");

  a_final_lf_done: assert property (@(posedge clk) disable iff (!rst_n)
    take && phase_r == PH_FINAL_LF && q_item.is_lf |=> out_valid_r && out_done_r)
    else $error("closing line did not produce a done result");

  a_data_emits: assert property (@(posedge clk) disable iff (!rst_n)
    take && phase_r == PH_DATA |=> out_valid_r && !out_done_r)
    else $error("data byte was not emitted");

endmodule

`default_nettype wire

FILE: rtl/http_chunked_body_decoder_top.sv
// Channel  | Ports                                        | Direction
// ---------+----------------------------------------------+----------
// input    | in_valid, in_ready, in_body_byte[7:0]        | in
// result   | out_valid, out_ready, out_payload_byte[7:0], | out
//          | out_message_done                             |
//
// One item per cycle sustained while out_ready stays high; the decode machine
// updates its state as each byte is taken. An item passes through the classify
// stage, then the queue, and its result is then loaded into the output register.
// Reset is synchronous and active low; it clears all control state at once.
// A stalled result holds in the output register while the classify stage and
// the two-entry queue fill; once all three hold an item, in_ready drops.
`default_nettype none

module http_chunked_body_decoder_top
  import hcbd_pkg::*;
#(
  parameter int SIZE_DIGITS = 9
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_body_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_payload_byte,
  output logic            out_message_done
);

  logic       push_valid;
  logic       push_ready;
  hcbd_item_t push_item;
  logic       q_valid;
  logic       q_ready;
  hcbd_item_t q_item;

  hcbd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_body_byte (in_body_byte),
    .push_valid   (push_valid),
    .push_item    (push_item),
    .push_ready   (push_ready)
  );

  hcbd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop_ready  (q_ready)
  );

  hcbd_back #(
    .SIZE_DIGITS (SIZE_DIGITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_ready          (q_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_payload_byte (out_payload_byte),
    .out_message_done (out_message_done)
  );

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DIGITS = 9;
  localparam int ACC_W = 4 * MAX_DIGITS;
  localparam int PHASE_ITEMS = 340;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [2:0] {
    PH_SIZE, PH_SIZE_LF, PH_DATA, PH_TRAIL1, PH_TRAIL2, PH_FINAL, PH_FINAL_LF
  } dec_phase_t;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_DATA, ROW_DONE} row_kind_t;

  typedef struct packed {
    logic [7:0] payload;
    logic       done;
  } result_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] b;
  } row_t;

  // Nine leading digits then an overflow digit, a lone CR in the size line,
  // two data bytes at the byte extremes, an invalid size character that ends
  // the message, and one trailer byte before the closing CRLF.
  localparam row_t DIR_ROWS [24] = '{
    '{ROW_PREDICT, "0"}, '{ROW_PREDICT, "0"}, '{ROW_PREDICT, "0"},
    '{ROW_PREDICT, "0"}, '{ROW_PREDICT, "0"}, '{ROW_PREDICT, "0"},
    '{ROW_PREDICT, "0"}, '{ROW_PREDICT, "0"}, '{ROW_PREDICT, "2"},
    '{ROW_PREDICT, "f"}, '{ROW_PREDICT, CH_CR}, '{ROW_PREDICT, "q"},
    '{ROW_PREDICT, CH_CR}, '{ROW_PREDICT, CH_LF},
    '{ROW_DATA, 8'h00}, '{ROW_DATA, 8'hFF},
    '{ROW_PREDICT, "x"}, '{ROW_PREDICT, "y"},
    '{ROW_PREDICT, "g"}, '{ROW_PREDICT, CH_CR}, '{ROW_PREDICT, CH_LF},
    '{ROW_PREDICT, "T"}, '{ROW_PREDICT, CH_CR}, '{ROW_DONE, CH_LF}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_body_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_payload_byte;
  logic       out_message_done;

  // Decoder state mirrored by the predictor.
  dec_phase_t       dec_phase = PH_SIZE;
  logic [ACC_W-1:0] size_acc = '0;
  logic [3:0]       digit_cnt = '0;
  logic [ACC_W-1:0] bytes_left = '0;
  logic             field_closed = 1'b0;

  result_t    pending_results[$];
  logic [7:0] body_stream[$];
  result_t    want;

  int in_idle_pct = 15;
  int out_idle_pct = 72;
  int items_sent = 0;
  int data_seen = 0;
  int done_seen = 0;
  int errors = 0;

  http_chunked_body_decoder_top #(
    .SIZE_DIGITS(MAX_DIGITS)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_body_byte     (in_body_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_payload_byte (out_payload_byte),
    .out_message_done (out_message_done)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int hex_nibble(input logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - "0");
    if (b >= "A" && b <= "F") return int'(b - "A") + 10;
    if (b >= "a" && b <= "f") return int'(b - "a") + 10;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + {4'h0, v};
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'h0, v} - 8'd10;
  endfunction

  task automatic clear_size_field();
    size_acc = '0;
    digit_cnt = '0;
    field_closed = 1'b0;
  endtask

  // Advances the decoder state by one body byte and gives the result it makes.
  task automatic decode_byte(input logic [7:0] b, output bit has_result,
                             output result_t r);
    int v;
    has_result = 1'b0;
    r = '0;
    case (dec_phase)
      PH_SIZE_LF: begin
        if (b == CH_LF) begin
          if (size_acc == '0) begin
            dec_phase = PH_FINAL;
          end else begin
            bytes_left = size_acc;
            dec_phase = PH_DATA;
          end
          clear_size_field();
        end else if (b != CH_CR) begin
          dec_phase = PH_SIZE;
        end
      end
      PH_DATA: begin
        has_result = 1'b1;
        r.payload = b;
        if (bytes_left != '0) bytes_left = bytes_left - 1'b1;
        if (bytes_left == '0) dec_phase = PH_TRAIL1;
      end
      PH_TRAIL1: dec_phase = PH_TRAIL2;
      PH_TRAIL2: begin
        dec_phase = PH_SIZE;
        clear_size_field();
      end
      PH_FINAL: begin
        if (b == CH_CR) dec_phase = PH_FINAL_LF;
      end
      PH_FINAL_LF: begin
        if (b == CH_LF) begin
          dec_phase = PH_SIZE;
          clear_size_field();
          bytes_left = '0;
          has_result = 1'b1;
          r.done = 1'b1;
        end else if (b != CH_CR) begin
          dec_phase = PH_FINAL;
        end
      end
      default: begin
        dec_phase = PH_SIZE;
        if (b == CH_CR) begin
          field_closed = 1'b1;
          dec_phase = PH_SIZE_LF;
        end else if (!field_closed) begin
          if (b == CH_SEMI || b == CH_SPACE) begin
            field_closed = 1'b1;
          end else begin
            v = hex_nibble(b);
            if (v < 0) begin
              size_acc = '0;
              field_closed = 1'b1;
            end else begin
              size_acc = {size_acc[ACC_W-5:0], 4'(v)};
              digit_cnt = digit_cnt + 4'd1;
              if (digit_cnt >= MAX_DIGITS) field_closed = 1'b1;
            end
          end
        end
      end
    endcase
  endtask

  // Offers one item, waits for the handshake, then records what it must produce.
  task automatic send_byte(input logic [7:0] b, input row_kind_t kind);
    bit      has_result;
    result_t r;
    @(negedge clk);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_body_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    decode_byte(b, has_result, r);
    case (kind)
      ROW_DATA: pending_results.push_back('{payload: b, done: 1'b0});
      ROW_DONE: pending_results.push_back('{payload: 8'h00, done: 1'b1});
      default: if (has_result) pending_results.push_back(r);
    endcase
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic push_size_field(input int unsigned size);
    logic [3:0]  nib[$];
    int unsigned s;
    s = size;
    do begin
      nib.push_front(4'(s));
      s = s >> 4;
    end while (s != 0);
    if ($urandom_range(0, 11) == 0) begin
      // Pad to the full digit count; the extra digits are skipped.
      while (nib.size() < MAX_DIGITS) nib.push_front(4'h0);
      repeat ($urandom_range(1, 2)) nib.push_back(4'($urandom_range(0, 15)));
    end else if ($urandom_range(0, 3) == 0) begin
      nib.push_front(4'h0);
    end
    foreach (nib[i]) body_stream.push_back(hex_char(nib[i]));
  endtask

  task automatic push_extension();
    logic [7:0] b;
    body_stream.push_back($urandom_range(0, 1) ? CH_SEMI : CH_SPACE);
    repeat ($urandom_range(0, 5)) begin
      b = 8'($urandom_range(0, 255));
      body_stream.push_back(b == CH_CR ? 8'h65 : b);
    end
  endtask

  task automatic push_lone_cr();
    body_stream.push_back(CH_CR);
    body_stream.push_back(8'($urandom_range(8'h21, 8'h7E)));
  endtask

  task automatic push_chunk(input int unsigned size);
    push_size_field(size);
    if ($urandom_range(0, 3) == 0) push_extension();
    if ($urandom_range(0, 9) == 0) push_lone_cr();
    body_stream.push_back(CH_CR);
    body_stream.push_back(CH_LF);
    repeat (size) body_stream.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 7) == 0) begin
      repeat (2) body_stream.push_back(8'($urandom_range(0, 255)));
    end else begin
      body_stream.push_back(CH_CR);
      body_stream.push_back(CH_LF);
    end
  endtask

  task automatic push_message();
    logic [7:0] b;
    repeat ($urandom_range(0, 3)) begin
      push_chunk($urandom_range(0, 9) == 0 ? $urandom_range(9, 40) : $urandom_range(1, 8));
    end
    // The last size line: zero, empty or carrying an invalid character.
    case ($urandom_range(0, 3))
      0: body_stream.push_back("0");
      1: begin
        body_stream.push_back("0");
        body_stream.push_back("0");
      end
      2: ;
      default: body_stream.push_back(8'($urandom_range(8'h67, 8'h7A)));
    endcase
    if ($urandom_range(0, 2) == 0) push_extension();
    body_stream.push_back(CH_CR);
    body_stream.push_back(CH_LF);
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        b = 8'($urandom_range(0, 255));
        body_stream.push_back(b == CH_CR ? 8'h54 : b);
      end
    end
    if ($urandom_range(0, 5) == 0) push_lone_cr();
    body_stream.push_back(CH_CR);
    body_stream.push_back(CH_LF);
  endtask

  // Random bytes with hex digits moved out of range, so that noise cannot
  // open a long chunk.
  task automatic push_noise();
    logic [7:0] b;
    repeat ($urandom_range(1, 6)) begin
      b = 8'($urandom_range(0, 255));
      if (hex_nibble(b) >= 0) b = b ^ 8'h40;
      body_stream.push_back(b);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] exp_val);
    $display("%0t ns: %s mismatch, got %02h, expected %02h", $realtime, what, got, exp_val);
    errors++;
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result, payload %02h done %0b", $realtime,
                 out_payload_byte, out_message_done);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_payload_byte !== want.payload) begin
          report_mismatch("payload_byte", out_payload_byte, want.payload);
        end
        if (out_message_done !== want.done) begin
          report_mismatch("message_done", {7'h0, out_message_done}, {7'h0, want.done});
        end
        if (want.done) done_seen++;
        else data_seen++;
      end
    end
  end

  initial begin
    int start_count;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIR_ROWS[i]) send_byte(DIR_ROWS[i].b, DIR_ROWS[i].kind);
    hold_until_drained();

    for (int p = 0; p < 3; p++) begin
      in_idle_pct = (p == 0) ? 15 : (p == 1) ? 72 : 0;
      out_idle_pct = (p == 0) ? 72 : (p == 1) ? 15 : 0;
      start_count = items_sent;
      while (items_sent - start_count < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) push_noise();
        else push_message();
        while (body_stream.size() != 0) send_byte(body_stream.pop_front(), ROW_PREDICT);
      end
      // The sender holds off here until every result of this stretch is back.
      hold_until_drained();
    end

    repeat (10) @(posedge clk);
    $display("Run covered %0d body bytes: %0d payload bytes and %0d message ends checked,",
             items_sent, data_seen, done_seen);
    $display("over directed cases and three mixes of sender and receiver stalls.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d results still pending", pending_results.size());
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
